/* design/mpw_pkg.sv */
`timescale 1ns / 1ps

package mpw_pkg;

    // configuration register map
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_SIDE    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 4'd1;

    localparam int SIDE_REG_BITS = 9;
    localparam int CHAN_REG_BITS = 11;
    localparam int CHAN_IDX_BITS = 10;

    localparam logic [SIDE_REG_BITS-1:0] IMAGE_SIDE_RESET    = 9'd55;
    localparam logic [CHAN_REG_BITS-1:0] CHANNEL_COUNT_RESET = 11'd96;
    localparam logic [CHAN_REG_BITS-1:0] CHANNEL_LIMIT       = 11'd1024;

    // per-pixel flags carried alongside the line buffer read
    typedef struct packed {
        logic in_range;
        logic emit;
        logic last_chan;
        logic last_img;
    } pix_flags_t;

endpackage

/* design/mpw_ram.sv */
`timescale 1ns / 1ps

module mpw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first on a same-address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/max_pool_window_stream_core.sv */
`timescale 1ns / 1ps

// channel   dir  signals                                   beat
// --------  ---  ----------------------------------------  -------------------------------
// s_        in   s_tvalid s_tready s_tdata                 one pixel, signed Q8.8
// m_        out  m_tvalid m_tready m_tdata m_tlast m_tuser  one pooled window maximum
// cfg_      in   cfg_valid cfg_ready cfg_index cfg_data    one register write
//
// one pixel is taken every cycle unless a waiting pooled beat holds the pixel stage;
// accepting a pixel loads the pixel stage and the line buffer read, and the window
// maximum is then loaded from the pixel stage into the output register
// the rate is set by the combinational column max and window max between the line
// buffer read register and the output register
// aresetn is synchronous and active low; it clears counters, valids and config
// registers, line buffer contents stay undefined until written
// a stalled m_ side holds the pixel stage and its line buffer read, and s_tready
// drops only when a waiting pooled beat blocks the next one

module max_pool_window_stream_core
    import mpw_pkg::*;
#(
    parameter int WINDOW    = 3,
    parameter int STRIDE    = 2,
    parameter int MAX_SIDE  = 256,
    parameter int DATA_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [DATA_BITS-1:0] pixel_value, rest zero
    input  logic [((DATA_BITS+7)/8)*8-1:0]    s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [DATA_BITS-2:0] pooled_value, rest zero
    output logic [((DATA_BITS-1+7)/8)*8-1:0]  m_tdata,
    output logic                              m_tlast,   // last_of_channel
    output logic                              m_tuser,   // [0] last_of_image

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          cfg_data
);

    localparam int CW    = $clog2(MAX_SIDE);          // column / row counter width
    localparam int SW    = CW + 1;                    // effective side width
    localparam int CMPW  = (SW > SIDE_REG_BITS) ? SW : SIDE_REG_BITS;
    localparam int SLW   = $clog2(WINDOW);            // line buffer slot index
    localparam int PHW   = (STRIDE > 1) ? $clog2(STRIDE) : 1;
    localparam int OUTW  = DATA_BITS - 1;
    localparam int MTW   = ((DATA_BITS - 1 + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SIDE_REG_BITS-1:0] image_side_reg;
    logic [CHAN_REG_BITS-1:0] channel_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_side_reg    <= IMAGE_SIDE_RESET;
            channel_count_reg <= CHANNEL_COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_SIDE:    image_side_reg    <= cfg_data[SIDE_REG_BITS-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHAN_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp side to 1..MAX_SIDE and channels to 1..CHANNEL_LIMIT
    logic [CMPW-1:0]          side_wide;
    logic [SW-1:0]            side_eff;
    logic [CHAN_REG_BITS-1:0] chans_eff;

    always_comb begin
        side_wide = CMPW'(image_side_reg);
        if (side_wide == '0) begin
            side_wide = CMPW'(1);
        end
        if (side_wide > CMPW'(MAX_SIDE)) begin
            side_wide = CMPW'(MAX_SIDE);
        end
        side_eff = side_wide[SW-1:0];

        chans_eff = channel_count_reg;
        if (chans_eff == '0) begin
            chans_eff = CHAN_REG_BITS'(1);
        end
        if (chans_eff > CHANNEL_LIMIT) begin
            chans_eff = CHANNEL_LIMIT;
        end
    end

    // ------------------------------------------------------------------
    // position counters and stride phases
    // ------------------------------------------------------------------
    logic [CW-1:0]            col_reg,  col_next;
    logic [CW-1:0]            row_reg,  row_next;
    logic [SLW-1:0]           slot_reg, slot_next;    // always row mod WINDOW
    logic [PHW-1:0]           cph_reg,  cph_next;     // column phase within stride
    logic [PHW-1:0]           rph_reg,  rph_next;     // row phase within stride
    logic [CHAN_IDX_BITS-1:0] chan_reg, chan_next;

    logic                     s_accept;
    logic [SW-1:0]            col_inc, row_inc;
    logic [CHAN_REG_BITS-1:0] chan_inc;
    logic                     col_wrap, row_wrap;
    logic                     col_grid, row_grid;
    pix_flags_t               flags_in;

    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        col_inc  = {1'b0, col_reg} + SW'(1);
        row_inc  = {1'b0, row_reg} + SW'(1);
        chan_inc = {1'b0, chan_reg} + CHAN_REG_BITS'(1);
        col_wrap = (col_inc >= side_eff);
        row_wrap = (row_inc >= side_eff);

        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        chan_next = chan_reg;

        if (col_wrap) begin
            col_next = '0;
            if (row_wrap) begin
                row_next  = '0;
                slot_next = '0;
                chan_next = (chan_inc >= chans_eff) ? '0 : chan_inc[CHAN_IDX_BITS-1:0];
            end else begin
                row_next  = row_inc[CW-1:0];
                slot_next = (slot_reg == SLW'(WINDOW - 1)) ? '0 : slot_reg + SLW'(1);
            end
        end else begin
            col_next = col_inc[CW-1:0];
        end

        // phase restarts at the first full-window position
        if ({1'b0, col_next} < SW'(WINDOW)) begin
            cph_next = '0;
        end else begin
            cph_next = (cph_reg == PHW'(STRIDE - 1)) ? '0 : cph_reg + PHW'(1);
        end
        if (row_next == row_reg) begin
            rph_next = rph_reg;
        end else if ({1'b0, row_next} < SW'(WINDOW)) begin
            rph_next = '0;
        end else begin
            rph_next = (rph_reg == PHW'(STRIDE - 1)) ? '0 : rph_reg + PHW'(1);
        end

        col_grid = ({1'b0, col_reg} >= SW'(WINDOW - 1)) && (cph_reg == '0);
        row_grid = ({1'b0, row_reg} >= SW'(WINDOW - 1)) && (rph_reg == '0);

        flags_in.in_range  = ({1'b0, col_reg} < side_eff) && ({1'b0, row_reg} < side_eff);
        flags_in.emit      = flags_in.in_range && (side_eff >= SW'(WINDOW))
                             && col_grid && row_grid;
        // a grid position is the last one when the next step would leave the image
        flags_in.last_chan = ((SW + 1)'(col_reg) + (SW + 1)'(STRIDE) >= (SW + 1)'(side_eff))
                             && ((SW + 1)'(row_reg) + (SW + 1)'(STRIDE) >= (SW + 1)'(side_eff));
        flags_in.last_img  = flags_in.last_chan && (chan_inc >= chans_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            cph_reg  <= '0;
            rph_reg  <= '0;
            chan_reg <= '0;
        end else if (s_accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            cph_reg  <= cph_next;
            rph_reg  <= rph_next;
            chan_reg <= chan_next;
        end
    end

    // ------------------------------------------------------------------
    // line buffers: one per row slot, written and read at the column
    // ------------------------------------------------------------------
    logic [DATA_BITS-1:0] lb_rd_data [WINDOW];

    for (genvar k = 0; k < WINDOW; k++) begin : g_line
        mpw_ram #(
            .WIDTH (DATA_BITS),
            .DEPTH (MAX_SIDE)
        ) u_line_ram (
            .aclk    (aclk),
            .wr_en   (s_accept && flags_in.in_range && (slot_reg == SLW'(k))),
            .wr_addr (col_reg),
            .wr_data (s_tdata[DATA_BITS-1:0]),
            .rd_en   (s_accept),
            .rd_addr (col_reg),
            .rd_data (lb_rd_data[k])
        );
    end

    // ------------------------------------------------------------------
    // pixel stage, held together with the line buffer read on a stall
    // ------------------------------------------------------------------
    logic                 pix_valid_reg;
    pix_flags_t           pix_flags_reg;
    logic [DATA_BITS-1:0] pix_data_reg;
    logic [SLW-1:0]       pix_slot_reg;
    logic                 pix_adv;

    assign pix_adv  = pix_valid_reg && (!pix_flags_reg.emit || !m_tvalid || m_tready);
    assign s_tready = !pix_valid_reg || pix_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg <= 1'b0;
        end else if (s_accept) begin
            pix_valid_reg <= 1'b1;
        end else if (pix_adv) begin
            pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_flags_reg <= flags_in;
            pix_data_reg  <= s_tdata[DATA_BITS-1:0];
            pix_slot_reg  <= slot_reg;
        end
    end

    // ------------------------------------------------------------------
    // column max of the new column, then max over the window
    // ------------------------------------------------------------------
    logic [OUTW-1:0]        colmax_reg [WINDOW-1];    // older columns, oldest first
    logic signed [DATA_BITS-1:0] col_best;
    logic [SLW:0]           sidx;
    logic [OUTW-1:0]        new_colmax;
    logic [OUTW-1:0]        win_max;

    always_comb begin
        col_best = signed'(pix_data_reg);
        if (col_best < 0) begin
            col_best = '0;
        end
        // older rows of the window, read from the other slots
        for (int i = 0; i < WINDOW - 1; i++) begin
            sidx = {1'b0, pix_slot_reg} + (SLW + 1)'(i + 1);
            if (sidx >= (SLW + 1)'(WINDOW)) begin
                sidx = sidx - (SLW + 1)'(WINDOW);
            end
            if (signed'(lb_rd_data[sidx[SLW-1:0]]) > col_best) begin
                col_best = signed'(lb_rd_data[sidx[SLW-1:0]]);
            end
        end
        new_colmax = col_best[OUTW-1:0];

        win_max = new_colmax;
        for (int j = 0; j < WINDOW - 1; j++) begin
            if (colmax_reg[j] > win_max) begin
                win_max = colmax_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_adv && pix_flags_reg.in_range) begin
            for (int j = 0; j < WINDOW - 2; j++) begin
                colmax_reg[j] <= colmax_reg[j + 1];
            end
            colmax_reg[WINDOW-2] <= new_colmax;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic            m_valid_reg;
    logic [OUTW-1:0] m_data_reg;
    logic            m_last_reg;
    logic            m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pix_adv && pix_flags_reg.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_adv && pix_flags_reg.emit) begin
            m_data_reg <= win_max;
            m_last_reg <= pix_flags_reg.last_chan;
            m_user_reg <= pix_flags_reg.last_img;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MTW'(m_data_reg);
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_img_ends_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser || m_tlast))
        else $error("image end flagged without channel end");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_reg <= SLW'(WINDOW - 1)))
        else $error("line buffer slot out of range");

    a_slot_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg == '0) |-> (slot_reg == '0))
        else $error("slot not aligned with row");

    a_emit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (pix_adv && pix_flags_reg.emit) |=> m_tvalid)
        else $error("pooled result lost");

endmodule

/* sim/mpw_checker.sv */
`timescale 1ns / 1ps

// watches all three channels, keeps its own copy of the pooling state and
// compares every pooled beat with the oldest one due
module mpw_checker
    import mpw_pkg::*;
#(
    parameter int WINDOW    = 3,
    parameter int STRIDE    = 2,
    parameter int MAX_SIDE  = 256,
    parameter int DATA_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [((DATA_BITS+7)/8)*8-1:0]    s_tdata,

    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [((DATA_BITS-1+7)/8)*8-1:0]  m_tdata,
    input  logic                              m_tlast,
    input  logic                              m_tuser,

    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          cfg_data,

    output int                                fail_count,
    output int                                pending,
    output int                                beats_checked
);

    localparam int OUT_W     = ((DATA_BITS-1+7)/8)*8;

    typedef struct packed {
        logic [DATA_BITS-2:0] value;
        logic                 chan_end;
        logic                 img_end;
    } pooled_beat_t;

    pooled_beat_t                pooled_due [$];
    logic signed [DATA_BITS-1:0] line_store [WINDOW*MAX_SIDE];
    logic [SIDE_REG_BITS-1:0]    side_cfg;
    logic [CHAN_REG_BITS-1:0]    chans_cfg;
    int                          row_pos;
    int                          col_pos;
    int                          chan_pos;

    function automatic bit on_grid(input int pos);
        return (pos >= WINDOW - 1) && (((pos - (WINDOW - 1)) % STRIDE) == 0);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("mismatch on pooled beat %0d: %s got 'h%0h want 'h%0h",
                 beats_checked, what, got, want);
    endtask

    always @(posedge aclk) begin : watch
        int                          side;
        int                          chans;
        int                          last_pos;
        int                          i;
        int                          j;
        logic signed [DATA_BITS-1:0] best;
        logic signed [DATA_BITS-1:0] sample;
        logic [OUT_W-1:0]            want_data;
        pooled_beat_t                beat;
        if (!aresetn) begin
            side_cfg      = IMAGE_SIDE_RESET;
            chans_cfg     = CHANNEL_COUNT_RESET;
            row_pos       = 0;
            col_pos       = 0;
            chan_pos      = 0;
            fail_count    = 0;
            pending       = 0;
            beats_checked = 0;
            foreach (line_store[k]) line_store[k] = '0;
            pooled_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_SIDE:    side_cfg  = cfg_data[SIDE_REG_BITS-1:0];
                    REG_CHANNEL_COUNT: chans_cfg = cfg_data[CHAN_REG_BITS-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                side  = (side_cfg == 0) ? 1 :
                        (int'(side_cfg) > MAX_SIDE) ? MAX_SIDE : int'(side_cfg);
                chans = (chans_cfg == 0) ? 1 :
                        (chans_cfg > CHANNEL_LIMIT) ? int'(CHANNEL_LIMIT) : int'(chans_cfg);
                if (row_pos < side && col_pos < side) begin
                    line_store[(row_pos % WINDOW) * MAX_SIDE + col_pos] =
                        s_tdata[DATA_BITS-1:0];
                    if (side >= WINDOW && on_grid(row_pos) && on_grid(col_pos)) begin
                        // maximum starts at zero, so all-negative windows give 0
                        best = '0;
                        for (i = 0; i < WINDOW; i++) begin
                            for (j = 0; j < WINDOW; j++) begin
                                sample = line_store[((row_pos - (WINDOW - 1) + i) % WINDOW)
                                                    * MAX_SIDE + col_pos - (WINDOW - 1) + j];
                                if (sample > best) best = sample;
                            end
                        end
                        last_pos      = (WINDOW - 1) + STRIDE * ((side - WINDOW) / STRIDE);
                        beat.value    = best[DATA_BITS-2:0];
                        beat.chan_end = (row_pos == last_pos) && (col_pos == last_pos);
                        beat.img_end  = beat.chan_end && (chan_pos + 1 >= chans);
                        pooled_due.push_back(beat);
                    end
                end
                // counters past a shrunk limit wrap on their next step
                if (col_pos + 1 >= side) begin
                    col_pos = 0;
                    if (row_pos + 1 >= side) begin
                        row_pos  = 0;
                        chan_pos = (chan_pos + 1 >= chans) ? 0 : chan_pos + 1;
                    end else begin
                        row_pos = row_pos + 1;
                    end
                end else begin
                    col_pos = col_pos + 1;
                end
            end

            if (m_tvalid && m_tready) begin
                if (pooled_due.size() == 0) begin
                    report_mismatch("beat with nothing due, tdata", 32'(m_tdata), '0);
                end else begin
                    beat      = pooled_due.pop_front();
                    want_data = '0;
                    want_data[DATA_BITS-2:0] = beat.value;
                    if (m_tdata !== want_data)
                        report_mismatch("pooled value", 32'(m_tdata), 32'(want_data));
                    if (m_tlast !== beat.chan_end)
                        report_mismatch("last of channel", 32'(m_tlast), 32'(beat.chan_end));
                    if (m_tuser !== beat.img_end)
                        report_mismatch("last of image", 32'(m_tuser), 32'(beat.img_end));
                    beats_checked++;
                end
            end
            pending = pooled_due.size();
        end
    end

endmodule

/* sim/tb_max_pool_window_stream_core.sv */
`timescale 1ns / 1ps

// stimulus and verdict for the pooling core; all prediction and comparison
// lives in the checker instance beside the block
module tb_max_pool_window_stream_core;
    import mpw_pkg::*;

    localparam int WINDOW    = 3;
    localparam int STRIDE    = 2;
    localparam int MAX_SIDE  = 256;
    localparam int DATA_BITS = 16;
    localparam int IN_W      = ((DATA_BITS+7)/8)*8;
    localparam int OUT_W     = ((DATA_BITS-1+7)/8)*8;

    // generous: the slowest legal run stays far below this
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PIXELS = 340;
    // a pixel passes the pixel stage and the output register; this covers that with room to spare
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PERCENT  = 28;

    // an index outside the register map, must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 4'd14;

    typedef enum logic [1:0] {
        PIX_ANY,
        PIX_NEGATIVE,
        PIX_NEAR_ZERO,
        PIX_EXTREME
    } pixel_mix_t;

    // two 3x3 channels: first all negative, second with the largest sample
    localparam logic [DATA_BITS-1:0] CORNER_PIXELS [18] = '{
        16'h8000, 16'hFFFF, 16'h8001, 16'hC000, 16'hFFFE,
        16'h8000, 16'hA5A5, 16'hFF00, 16'h8000,
        16'h0000, 16'h0001, 16'hFFFF, 16'h4000, 16'h7FFF,
        16'h8000, 16'h00FF, 16'h5A5A, 16'h0100
    };

    // first random phases pin the out-of-range and extreme settings
    localparam int EDGE_PHASES = 5;
    localparam int EDGE_SIDE  [EDGE_PHASES] = '{0,  2,    9,   511, 3};
    localparam int EDGE_CHANS [EDGE_PHASES] = '{0,  2047, 3,   1024, 1024};
    localparam int EDGE_COUNT [EDGE_PHASES] = '{20, 20,   150, 40,  45};
    // phase with no idling on either side
    localparam int CALM_PHASE = 2;

    logic                        aclk = 1'b0;
    logic                        aresetn;

    logic                        s_tvalid;
    logic                        s_tready;
    logic [IN_W-1:0]             s_tdata;

    logic                        m_tvalid;
    logic                        m_tready;
    logic [OUT_W-1:0]            m_tdata;
    logic                        m_tlast;
    logic                        m_tuser;

    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;

    int                          fail_count;
    int                          pending;
    int                          beats_checked;
    int                          cycle_count = 0;
    int                          pixels_sent = 0;
    int                          settings_tried = 0;
    logic                        calm;

    max_pool_window_stream_core #(
        .WINDOW    (WINDOW),
        .STRIDE    (STRIDE),
        .MAX_SIDE  (MAX_SIDE),
        .DATA_BITS (DATA_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mpw_checker #(
        .WINDOW    (WINDOW),
        .STRIDE    (STRIDE),
        .MAX_SIDE  (MAX_SIDE),
        .DATA_BITS (DATA_BITS)
    ) pool_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped at the cycle limit with %0d pooled beats still due", pending);
        $display("tb_max_pool_window_stream_core: errors");
        $finish;
    end

    // result side back-pressure, off during the calm stretch
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // sample mixes: full range, all negative, small around zero, extremes
    function automatic logic [DATA_BITS-1:0] pick_pixel(input pixel_mix_t mix);
        logic [DATA_BITS-1:0] raw;
        int                   near;
        raw  = DATA_BITS'($urandom());
        near = int'($urandom_range(512)) - 256;
        case (mix)
            PIX_NEGATIVE:  raw[DATA_BITS-1] = 1'b1;
            PIX_NEAR_ZERO: raw = near[DATA_BITS-1:0];
            PIX_EXTREME: begin
                case ($urandom_range(4))
                    0: raw = 16'h7FFF;
                    1: raw = 16'h8000;
                    2: raw = 16'h0000;
                    3: raw = 16'hFFFF;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return raw;
    endfunction

    // enters and leaves at a falling edge; tvalid stays high across back-to-back beats
    task automatic send_pixel(input logic [DATA_BITS-1:0] px);
        if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_W'($urandom());
            do @(negedge aclk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic feed(input int count, input pixel_mix_t mix);
        repeat (count) send_pixel(pick_pixel(mix));
        s_tvalid <= 1'b0;
    endtask

    // every due beat in, then a settle time for a pixel that makes none
    task automatic wait_idle();
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int         phase;
        int         side;
        int         chans;
        int         eff_side;
        int         count;
        int         random_pixels;
        int         pick;
        pixel_mix_t mix;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // smallest image, two channels, negative window then the largest sample
        write_reg(REG_IMAGE_SIDE, 11'd3);
        write_reg(REG_CHANNEL_COUNT, 11'd2);
        write_reg(REG_UNUSED, 11'h7FF);
        foreach (CORNER_PIXELS[k]) send_pixel(CORNER_PIXELS[k]);
        s_tvalid <= 1'b0;

        // three full-width rows: fills every line store entry, so later
        // setting changes never pull in an entry that was never written
        write_reg(REG_IMAGE_SIDE, CFG_DATA_BITS'(MAX_SIDE));
        write_reg(REG_CHANNEL_COUNT, 11'd1);
        feed(WINDOW * MAX_SIDE, PIX_ANY);

        // shrink the side with the counters mid-image, then run it out
        write_reg(REG_IMAGE_SIDE, 11'd7);
        feed(77, PIX_NEAR_ZERO);
        settings_tried = 3;

        random_pixels = 0;
        phase         = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            if (phase < EDGE_PHASES) begin
                side  = EDGE_SIDE[phase];
                chans = EDGE_CHANS[phase];
                count = EDGE_COUNT[phase];
            end else begin
                pick = $urandom_range(99);
                if (pick < 60)      side = $urandom_range(11, 3);
                else if (pick < 70) side = $urandom_range(2, 0);
                else if (pick < 80) side = $urandom_range(31, 12);
                else if (pick < 86) side = MAX_SIDE;
                else if (pick < 92) side = $urandom_range(511, MAX_SIDE + 1);
                else                side = $urandom_range(MAX_SIDE - 1, 32);

                pick = $urandom_range(99);
                if (pick < 65)      chans = $urandom_range(4, 1);
                else if (pick < 75) chans = 0;
                else if (pick < 83) chans = int'(CHANNEL_LIMIT);
                else if (pick < 90) chans = $urandom_range(2047, int'(CHANNEL_LIMIT) + 1);
                else                chans = $urandom_range(40, 5);

                // big sides get short bursts, small ones mostly whole images
                eff_side = (side == 0) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : side;
                if (eff_side >= 32)
                    count = $urandom_range(60, 1);
                else if (eff_side >= 12)
                    count = eff_side * $urandom_range(6, 3);
                else if ($urandom_range(3) == 0)
                    count = $urandom_range(40, 1);
                else
                    count = eff_side * eff_side * $urandom_range(3, 1);
            end
            // keep the total near the planned pixel budget
            if (count > RANDOM_PIXELS - random_pixels)
                count = RANDOM_PIXELS - random_pixels;
            mix  = pixel_mix_t'($urandom_range(3));
            calm <= (phase == CALM_PHASE);
            write_reg(REG_IMAGE_SIDE, CFG_DATA_BITS'(side));
            write_reg(REG_CHANNEL_COUNT, CFG_DATA_BITS'(chans));
            feed(count, mix);
            random_pixels += count;
            settings_tried++;
            phase++;
        end
        calm <= 1'b0;

        wait_idle();
        $display("covered %0d pixels over %0d register settings, %0d pooled beats checked",
                 pixels_sent, settings_tried, beats_checked);
        $display("sides 0 to 511 and channel counts 0 to 2047, with writes landing mid-image");
        if (fail_count == 0) begin
            $display("tb_max_pool_window_stream_core: clean");
        end else begin
            $display("tb_max_pool_window_stream_core: errors");
        end
        $finish;
    end

endmodule
